// ----- hw/rtl/ipcmb_pkg.sv -----
package ipcmb_pkg;

   localparam int unsigned DEFAULT_FIFO_DEPTH = 16;

   // register select codes
   localparam logic [1:0] REG_SYNC = 2'd0;
   localparam logic [1:0] REG_CTRL = 2'd1;
   localparam logic [1:0] REG_SEND = 2'd2;
   localparam logic [1:0] REG_RECV = 2'd3;

   // access sizes; anything above halfword is a full word
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic        side;
      logic        operation;
      logic [1:0]  register_select;
      logic [1:0]  access_size;
      logic [1:0]  byte_offset;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_to_other;
      logic [1:0]  error;
   } rsp_type;

   // one FIFO operation per accepted word
   typedef struct packed {
      logic        push;
      logic        pop;
      logic        fifo_sel;
      logic [31:0] wdata;
   } fifo_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic last_slot;  // one entry short of full
      logic one_left;   // exactly one entry held
   } fifo_stat_type;

   function automatic logic [4:0] lane_shift(logic [1:0] size, logic [1:0] off);
      logic [4:0] sh;
      if (size == SIZE_BYTE) begin
         sh = {off, 3'b000};
      end else begin
         sh = {off[1], 4'b0000};
      end
      return sh;
   endfunction

   function automatic logic [31:0] lane_merge(logic [31:0] old, logic [31:0] data,
                                              logic [1:0] size, logic [1:0] off);
      logic [31:0] mask;
      logic [4:0]  sh;
      sh = lane_shift(size, off);
      if (size == SIZE_BYTE || size == SIZE_HALF) begin
         mask = ((size == SIZE_BYTE) ? 32'h0000_00FF : 32'h0000_FFFF) << sh;
         return (old & ~mask) | ((data << sh) & mask);
      end
      return data;
   endfunction

   function automatic logic [31:0] lane_pick(logic [31:0] word, logic [1:0] size,
                                             logic [1:0] off);
      logic [31:0] shifted;
      shifted = word >> lane_shift(size, off);
      if (size == SIZE_BYTE) begin
         return shifted & 32'h0000_00FF;
      end else if (size == SIZE_HALF) begin
         return shifted & 32'h0000_FFFF;
      end
      return word;
   endfunction

endpackage

// ----- hw/rtl/ipcmb_chan_if.sv -----
interface ipcmb_chan_if #(
   parameter type payload_type = logic [31:0]
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/interprocessor_sync_fifo_mailbox.sv -----
// Channel   Dir  Payload              Handshake
// req_chan  in   ipcmb_pkg::req_type  valid/ready, taken when both high
// rsp_chan  out  ipcmb_pkg::rsp_type  valid/ready, one word per request
//
// A receive read that finds data passes through an extra register, since the FIFO
// word is registered out of the storage array before the response is built.
// The response sits in an output register; the next request is taken only when
// that register is empty or drained by the same edge, and never while a memory
// read is open.
// Reset (synchronous) empties both FIFOs and clears sync, send and flag state;
// array contents are not cleared and need no clearing pass.
module interprocessor_sync_fifo_mailbox #(
   parameter int unsigned FIFO_DEPTH = ipcmb_pkg::DEFAULT_FIFO_DEPTH
) (
   input logic          clock,
   input logic          reset,
   ipcmb_chan_if.sink   req_chan,
   ipcmb_chan_if.source rsp_chan
);

   ipcmb_pkg::req_type            rq;
   ipcmb_pkg::fifo_cmd_type       fifo_cmd;
   ipcmb_pkg::fifo_stat_type [1:0] fifo_stat;
   logic [31:0]                   fifo_rdata;

   logic [31:0] sync_word_ff [2];
   logic [31:0] sync_word_in [2];
   logic [31:0] send_word_ff [2];
   logic [31:0] send_word_in [2];
   logic [3:0]  sync_nibble_ff [2];
   logic [3:0]  sync_nibble_in [2];
   logic [1:0]  remote_flags_ff [2];   // bit 0 empty, bit 1 full
   logic [1:0]  remote_flags_in [2];

   logic               busy_ff, busy_in;         // receive read waiting on array
   logic [1:0]         pend_size_ff, pend_size_in;
   logic [1:0]         pend_off_ff, pend_off_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ipcmb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        s, o;
   logic        accept;
   logic        is_wr;
   logic [31:0] sync_merged;
   logic [31:0] send_merged;
   logic [31:0] rd_word;
   logic [1:0]  err;
   logic        pop_hit;

   ipcmb_store #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (fifo_cmd),
      .rdata (fifo_rdata),
      .stat  (fifo_stat)
   );

   assign rq = req_chan.payload;
   // a stalled response or an open array read holds off the next word
   assign req_chan.ready   = !busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      s     = rq.side;
      o     = ~rq.side;
      is_wr = (rq.operation == ipcmb_pkg::OP_WRITE);

      sync_merged = ipcmb_pkg::lane_merge(sync_word_ff[s], rq.write_data,
                                          rq.access_size, rq.byte_offset);
      send_merged = ipcmb_pkg::lane_merge(send_word_ff[s], rq.write_data,
                                          rq.access_size, rq.byte_offset);

      for (int i = 0; i < 2; i++) begin
         sync_word_in[i]    = sync_word_ff[i];
         send_word_in[i]    = send_word_ff[i];
         sync_nibble_in[i]  = sync_nibble_ff[i];
         remote_flags_in[i] = remote_flags_ff[i];
      end

      fifo_cmd.push     = 1'b0;
      fifo_cmd.pop      = 1'b0;
      fifo_cmd.fifo_sel = s;
      fifo_cmd.wdata    = send_merged;

      rd_word = '0;
      err     = ipcmb_pkg::ERR_NONE;
      pop_hit = 1'b0;

      if (is_wr) begin
         case (rq.register_select)
            ipcmb_pkg::REG_SYNC: begin
               sync_word_in[s]   = sync_merged;
               sync_nibble_in[o] = sync_merged[11:8];
            end
            ipcmb_pkg::REG_SEND: begin
               send_word_in[s] = send_merged;
               fifo_cmd.push   = accept;
               // flags as the own FIFO stands after the push
               if (fifo_stat[s].full) begin
                  err                = ipcmb_pkg::ERR_OVERFLOW;
                  remote_flags_in[o] = 2'b10;
               end else begin
                  remote_flags_in[o] = {fifo_stat[s].last_slot, 1'b0};
               end
            end
            default: begin
               // control and receive writes are ignored
            end
         endcase
      end else begin
         case (rq.register_select)
            ipcmb_pkg::REG_SYNC: rd_word = {28'd0, sync_nibble_ff[s]};
            ipcmb_pkg::REG_CTRL: rd_word = {22'd0, remote_flags_ff[s], 6'd0,
                                            fifo_stat[s].full, fifo_stat[s].empty};
            ipcmb_pkg::REG_SEND: rd_word = send_word_ff[s];
            ipcmb_pkg::REG_RECV: begin
               fifo_cmd.fifo_sel = o;
               fifo_cmd.pop      = accept;
               if (fifo_stat[o].empty) begin
                  err                = ipcmb_pkg::ERR_UNDERFLOW;
                  remote_flags_in[s] = 2'b01;
               end else begin
                  pop_hit            = 1'b1;
                  remote_flags_in[s] = {1'b0, fifo_stat[o].one_left};
               end
            end
            default: rd_word = '0;
         endcase
      end

      if (!accept) begin
         for (int i = 0; i < 2; i++) begin
            sync_word_in[i]    = sync_word_ff[i];
            send_word_in[i]    = send_word_ff[i];
            sync_nibble_in[i]  = sync_nibble_ff[i];
            remote_flags_in[i] = remote_flags_ff[i];
         end
      end

      busy_in      = busy_ff;
      pend_size_in = pend_size_ff;
      pend_off_in  = pend_off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;

      if (busy_ff) begin
         // popped word is now out of the array
         busy_in                  = 1'b0;
         rsp_valid_in             = 1'b1;
         rsp_data_in.read_data    = ipcmb_pkg::lane_pick(fifo_rdata, pend_size_ff,
                                                         pend_off_ff);
         rsp_data_in.irq_to_other = 1'b0;
         rsp_data_in.error        = ipcmb_pkg::ERR_NONE;
      end else if (accept) begin
         if (pop_hit) begin
            busy_in      = 1'b1;
            pend_size_in = rq.access_size;
            pend_off_in  = rq.byte_offset;
            rsp_valid_in = 1'b0;
         end else begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.read_data    = is_wr ? 32'd0
                                       : ipcmb_pkg::lane_pick(rd_word, rq.access_size,
                                                              rq.byte_offset);
            rsp_data_in.irq_to_other = is_wr &&
                                       (rq.register_select == ipcmb_pkg::REG_SEND);
            rsp_data_in.error        = err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            sync_word_ff[i]    <= '0;
            send_word_ff[i]    <= '0;
            sync_nibble_ff[i]  <= '0;
            remote_flags_ff[i] <= '0;
         end
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 2; i++) begin
            sync_word_ff[i]    <= sync_word_in[i];
            send_word_ff[i]    <= send_word_in[i];
            sync_nibble_ff[i]  <= sync_nibble_in[i];
            remote_flags_ff[i] <= remote_flags_in[i];
         end
      end
   end

   // response payload and pending lane info, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      pend_size_ff <= pend_size_in;
      pend_off_ff  <= pend_off_in;
   end

endmodule

// ----- hw/rtl/ipcmb_store.sv -----
module ipcmb_store #(
   parameter int unsigned FIFO_DEPTH = ipcmb_pkg::DEFAULT_FIFO_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ipcmb_pkg::fifo_cmd_type         cmd,
   output logic [31:0]                     rdata,
   output ipcmb_pkg::fifo_stat_type [1:0]  stat
);

   localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [31:0]      fifo_mem [2][FIFO_DEPTH];
   logic [31:0]      rdata_ff;
   logic [CNT_W-1:0] count_ff [2];
   logic [CNT_W-1:0] count_in [2];
   logic [PTR_W-1:0] rd_ptr_ff [2];
   logic [PTR_W-1:0] rd_ptr_in [2];

   logic [CNT_W:0]   wr_sum;
   logic [PTR_W-1:0] wr_idx;
   logic [PTR_W-1:0] rd_idx;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      for (int f = 0; f < 2; f++) begin
         stat[f].empty     = (count_ff[f] == '0);
         stat[f].full      = (count_ff[f] == CNT_W'(FIFO_DEPTH));
         stat[f].last_slot = (count_ff[f] == CNT_W'(FIFO_DEPTH - 1));
         stat[f].one_left  = (count_ff[f] == CNT_W'(1));
      end
   end

   always_comb begin
      do_push = cmd.push && !stat[cmd.fifo_sel].full;
      do_pop  = cmd.pop && !stat[cmd.fifo_sel].empty;
      rd_idx  = rd_ptr_ff[cmd.fifo_sel];
      // pointer plus count stays under twice the depth: one subtract wraps it
      wr_sum  = {1'b0, count_ff[cmd.fifo_sel]} + (CNT_W + 1)'(rd_idx);
      if (wr_sum >= (CNT_W + 1)'(FIFO_DEPTH)) begin
         wr_sum = wr_sum - (CNT_W + 1)'(FIFO_DEPTH);
      end
      wr_idx = wr_sum[PTR_W-1:0];

      for (int f = 0; f < 2; f++) begin
         count_in[f]  = count_ff[f];
         rd_ptr_in[f] = rd_ptr_ff[f];
      end
      if (do_push) begin
         count_in[cmd.fifo_sel] = count_ff[cmd.fifo_sel] + CNT_W'(1);
      end
      if (do_pop) begin
         count_in[cmd.fifo_sel] = count_ff[cmd.fifo_sel] - CNT_W'(1);
         if (rd_idx == PTR_W'(FIFO_DEPTH - 1)) begin
            rd_ptr_in[cmd.fifo_sel] = '0;
         end else begin
            rd_ptr_in[cmd.fifo_sel] = rd_idx + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < 2; f++) begin
            count_ff[f]  <= '0;
            rd_ptr_ff[f] <= '0;
         end
      end else begin
         for (int f = 0; f < 2; f++) begin
            count_ff[f]  <= count_in[f];
            rd_ptr_ff[f] <= rd_ptr_in[f];
         end
      end
   end

   // storage, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_mem[cmd.fifo_sel][wr_idx] <= cmd.wdata;
      end
      if (do_pop) begin
         rdata_ff <= fifo_mem[cmd.fifo_sel][rd_idx];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/ipcmb_checker.sv -----
module ipcmb_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ipcmb_pkg::rsp_type rsp_payload
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response dropped or changed");

   a_irq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.irq_to_other |->
         rsp_payload.read_data == 32'd0 &&
         rsp_payload.error != ipcmb_pkg::ERR_UNDERFLOW)
      else $error("send response carries read data or underflow");

   a_overflow_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error == ipcmb_pkg::ERR_OVERFLOW |->
         rsp_payload.irq_to_other)
      else $error("overflow outside a send");

   a_underflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error == ipcmb_pkg::ERR_UNDERFLOW |->
         rsp_payload.read_data == 32'd0)
      else $error("underflow with nonzero data");

endmodule

bind interprocessor_sync_fifo_mailbox ipcmb_checker u_ipcmb_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

// ----- test/interprocessor_sync_fifo_mailbox_chk.sv -----
`timescale 1ns / 100ps
module interprocessor_sync_fifo_mailbox_chk
   import ipcmb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_word,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_word,
   output int      mismatch_count,
   output int      words_owed
);

   localparam int unsigned DEPTH = DEFAULT_FIFO_DEPTH;

   // mirror of the mailbox, one entry per side
   logic [31:0] mbox_mem   [2][DEPTH];
   int unsigned mbox_fill  [2];
   int unsigned mbox_head  [2];
   logic [3:0]  sync_seen  [2];
   logic [1:0]  peer_flags [2];
   logic [31:0] sync_held  [2];
   logic [31:0] send_held  [2];
   rsp_type     owed_q [$];

   function automatic int unsigned lane_bit(logic [1:0] size, logic [1:0] off);
      if (size == SIZE_BYTE) begin
         return 8 * off;
      end
      return 16 * off[1];
   endfunction

   function automatic logic [31:0] lane_mask(logic [1:0] size, logic [1:0] off);
      return ((size == SIZE_BYTE) ? 32'h0000_00FF : 32'h0000_FFFF) << lane_bit(size, off);
   endfunction

   function automatic logic [31:0] merge_lane(logic [31:0] old, logic [31:0] data,
                                              logic [1:0] size, logic [1:0] off);
      logic [31:0] m;
      if (size != SIZE_BYTE && size != SIZE_HALF) begin
         return data;
      end
      m = lane_mask(size, off);
      return (old & ~m) | ((data << lane_bit(size, off)) & m);
   endfunction

   function automatic logic [31:0] pick_lane(logic [31:0] word, logic [1:0] size,
                                             logic [1:0] off);
      if (size != SIZE_BYTE && size != SIZE_HALF) begin
         return word;
      end
      return (word & lane_mask(size, off)) >> lane_bit(size, off);
   endfunction

   // bit 0 empty, bit 1 full
   function automatic logic [1:0] fill_flags(logic f);
      return {mbox_fill[f] >= DEPTH, mbox_fill[f] == 0};
   endfunction

   function automatic rsp_type apply_access(req_type a);
      rsp_type     r;
      logic        s;
      logic        o;
      logic [31:0] word;
      r    = '0;
      word = '0;
      s    = a.side;
      o    = ~a.side;
      if (a.operation == OP_WRITE) begin
         case (a.register_select)
            REG_SYNC: begin
               sync_held[s] = merge_lane(sync_held[s], a.write_data, a.access_size,
                                         a.byte_offset);
               sync_seen[o] = sync_held[s][11:8];
            end
            REG_SEND: begin
               send_held[s] = merge_lane(send_held[s], a.write_data, a.access_size,
                                         a.byte_offset);
               if (mbox_fill[s] >= DEPTH) begin
                  r.error = ERR_OVERFLOW;
               end else begin
                  mbox_mem[s][(mbox_head[s] + mbox_fill[s]) % DEPTH] = send_held[s];
                  mbox_fill[s]++;
               end
               peer_flags[o]  = fill_flags(s);
               r.irq_to_other = 1'b1;
            end
            default: ;  // control and receive writes are dropped
         endcase
      end else begin
         case (a.register_select)
            REG_SYNC: word = {28'h0, sync_seen[s]};
            REG_CTRL: word = {22'h0, peer_flags[s], 6'h0, fill_flags(s)};
            REG_SEND: word = send_held[s];
            default: begin
               if (mbox_fill[o] == 0) begin
                  r.error = ERR_UNDERFLOW;
               end else begin
                  word         = mbox_mem[o][mbox_head[o]];
                  mbox_head[o] = (mbox_head[o] + 1) % DEPTH;
                  mbox_fill[o]--;
               end
               peer_flags[s] = fill_flags(o);
            end
         endcase
         r.read_data = pick_lane(word, a.access_size, a.byte_offset);
      end
      return r;
   endfunction

   function automatic void flag_mismatch(string msg);
      if (mismatch_count < 10) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            mbox_fill[i]  = 0;
            mbox_head[i]  = 0;
            sync_seen[i]  = '0;
            peer_flags[i] = '0;
            sync_held[i]  = '0;
            send_held[i]  = '0;
         end
         owed_q.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            owed_q.push_back(apply_access(req_word));
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected word data=%h irq=%b err=%0d",
                                       rsp_word.read_data, rsp_word.irq_to_other,
                                       rsp_word.error));
            end else begin
               want = owed_q.pop_front();
               if (rsp_word.read_data !== want.read_data
                   || rsp_word.irq_to_other !== want.irq_to_other
                   || rsp_word.error !== want.error) begin
                  flag_mismatch($sformatf(
                     "exp data=%h irq=%b err=%0d, got data=%h irq=%b err=%0d",
                     want.read_data, want.irq_to_other, want.error,
                     rsp_word.read_data, rsp_word.irq_to_other, rsp_word.error));
               end
            end
         end
      end
      words_owed = owed_q.size();
   end

endmodule

// ----- test/interprocessor_sync_fifo_mailbox_tb.sv -----
`timescale 1ns / 100ps
module interprocessor_sync_fifo_mailbox_tb;
   import ipcmb_pkg::*;

   localparam int unsigned DEPTH       = DEFAULT_FIFO_DEPTH;
   localparam int unsigned ITEM_TARGET = 2000;
   // word-sized accesses; size 3 must behave like size 2
   localparam logic [1:0]  SIZE_WORD   = 2'd2;
   localparam logic [1:0]  SIZE_WIDE   = 2'd3;
   // long receiver hold-off so the response register backs up into the request side
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          mismatch_count;
   int          words_owed;
   int unsigned words_sent     = 0;
   // when set, that side runs back-to-back with no idle cycles
   bit          sender_eager   = 1'b0;
   bit          receiver_eager = 1'b0;

   always #5 clock = ~clock;

   ipcmb_chan_if #(.payload_type(req_type)) req_chan ();
   ipcmb_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   interprocessor_sync_fifo_mailbox dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // watches both channels, predicts each response and compares
   interprocessor_sync_fifo_mailbox_chk mailbox_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_word       (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_word       (rsp_chan.payload),
      .mismatch_count (mismatch_count),
      .words_owed     (words_owed)
   );

   function automatic logic [1:0] rand_2b();
      return 2'($urandom_range(0, 3));
   endfunction

   // Offer one access: idle a random number of cycles, then hold valid until taken.
   // Valid is only dropped when a gap is drawn, so back-to-back words keep it high.
   task automatic post(logic side, logic op, logic [1:0] sel, logic [1:0] size,
                       logic [1:0] off, logic [31:0] data);
      req_type     w;
      int unsigned gap;
      w.side            = side;
      w.operation       = op;
      w.register_select = sel;
      w.access_size     = size;
      w.byte_offset     = off;
      w.write_data      = data;
      gap = sender_eager ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= w;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      // control and receive writes do nothing, so they do not count
      if (!(op == OP_WRITE && (sel == REG_CTRL || sel == REG_RECV))) begin
         words_sent++;
      end
      if ($urandom_range(0, 99) < 3) begin
         sender_eager = ~sender_eager;
      end
   endtask

   // Request side
   initial begin : stimulus
      logic        s;
      int unsigned n;
      int unsigned m;
      int unsigned pick;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // receive from empty mailboxes on both sides: underflow, data zero
      post(1'b0, OP_READ, REG_RECV, SIZE_WORD, 2'd0, 32'h0);
      post(1'b1, OP_READ, REG_RECV, SIZE_BYTE, 2'd3, 32'hFFFF_FFFF);
      post(1'b0, OP_READ, REG_CTRL, SIZE_WORD, 2'd0, 32'h0);
      // sync: all ones from side 0 shows up as nibble F on side 1
      post(1'b0, OP_WRITE, REG_SYNC, SIZE_WORD, 2'd0, 32'hFFFF_FFFF);
      post(1'b1, OP_READ, REG_SYNC, SIZE_WORD, 2'd0, 32'h0);
      // byte write into lane 1 lands on bits 8..15
      post(1'b1, OP_WRITE, REG_SYNC, SIZE_BYTE, 2'd1, 32'h0000_00A5);
      post(1'b0, OP_READ, REG_SYNC, SIZE_BYTE, 2'd0, 32'h0);
      // halfword write only looks at offset bit 1; merge keeps bits 8..11 set
      post(1'b0, OP_WRITE, REG_SYNC, SIZE_HALF, 2'd3, 32'h0000_0000);
      post(1'b1, OP_READ, REG_SYNC, SIZE_WIDE, 2'd0, 32'h0);
      // sends of every size build up side 0's mailbox
      post(1'b0, OP_WRITE, REG_SEND, SIZE_WORD, 2'd0, 32'h0000_0000);
      post(1'b0, OP_WRITE, REG_SEND, SIZE_BYTE, 2'd2, 32'h0000_00C3);
      post(1'b0, OP_WRITE, REG_SEND, SIZE_HALF, 2'd1, 32'h0000_BEEF);
      post(1'b0, OP_WRITE, REG_SEND, SIZE_WIDE, 2'd0, 32'hFFFF_FFFF);
      post(1'b0, OP_READ, REG_SEND, SIZE_HALF, 2'd2, 32'h0);
      post(1'b1, OP_READ, REG_CTRL, SIZE_WORD, 2'd0, 32'h0);
      post(1'b0, OP_READ, REG_CTRL, SIZE_BYTE, 2'd1, 32'h0);
      // writes to control and receive registers are ignored
      post(1'b0, OP_WRITE, REG_CTRL, SIZE_WORD, 2'd0, 32'hFFFF_FFFF);
      post(1'b1, OP_WRITE, REG_RECV, SIZE_WORD, 2'd0, 32'hFFFF_FFFF);
      // side 1 drains side 0's mailbox with reads of every size, then underflows
      post(1'b1, OP_READ, REG_RECV, SIZE_WORD, 2'd0, 32'h0);
      post(1'b1, OP_READ, REG_RECV, SIZE_BYTE, 2'd2, 32'h0);
      post(1'b1, OP_READ, REG_RECV, SIZE_HALF, 2'd2, 32'h0);
      post(1'b1, OP_READ, REG_RECV, SIZE_WIDE, 2'd1, 32'h0);
      post(1'b1, OP_READ, REG_RECV, SIZE_WORD, 2'd0, 32'h0);
      post(1'b1, OP_READ, REG_CTRL, SIZE_WORD, 2'd0, 32'h0);

      // --- random ---
      // Half of the picks are message bursts: one side sends a run (sometimes past full, so
      // the overflow path is hit), the peer sometimes checks flags, then drains some or all
      // of it, sometimes past empty. The rest is sync traffic and pure noise.
      while (words_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         s    = 1'($urandom_range(0, 1));
         if (pick < 5) begin
            n = $urandom_range(1, DEPTH + 4);
            repeat (n) post(s, OP_WRITE, REG_SEND, rand_2b(), rand_2b(), $urandom());
            if ($urandom_range(0, 1) == 1) begin
               post(~s, OP_READ, REG_CTRL, rand_2b(), rand_2b(), $urandom());
            end
            m = $urandom_range(0, n + 3);
            repeat (m) post(~s, OP_READ, REG_RECV, rand_2b(), rand_2b(), $urandom());
         end else if (pick < 7) begin
            post(s, OP_WRITE, REG_SYNC, rand_2b(), rand_2b(), $urandom());
            post(~s, OP_READ, REG_SYNC, rand_2b(), rand_2b(), $urandom());
         end else begin
            post(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_2b(),
                 rand_2b(), rand_2b(), $urandom());
         end
      end
      req_chan.valid <= 1'b0;

      // wait for every predicted response, bounded, then let the pipe settle
      n = 0;
      while (words_owed != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && words_owed == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Response side: random stalls per word, eager stretches, and two long
   // hold-offs while the request side keeps offering
   initial begin : response_sink
      int unsigned stall;
      int unsigned taken;
      rsp_chan.ready = 1'b0;
      taken          = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (taken == 40 || taken == 900) begin
            stall = HOLD_CYCLES;
         end else begin
            stall = receiver_eager ? 0 : $urandom_range(0, 15);
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
         taken++;
         if ($urandom_range(0, 99) < 3) begin
            receiver_eager = ~receiver_eager;
         end
      end
   end

   // watchdog, well beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
